// ===== rtl/hpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg
// shared widths, fixed-point constants, command/status types and the
// arctangent table for the haversine path length block
// ----------------------------------------------------------------------------
package hpl_pkg;

   localparam int LAT_W      = 31;
   localparam int LON_W      = 32;
   localparam int POS_W      = 32;
   localparam int STEP_W     = 35;
   localparam int TOTAL_BITS = 48;
   localparam int RADIUS_W   = 23;

   localparam int DW    = 34;   // coordinate difference
   localparam int MAG_W = 31;   // magnitude fed to the angle scaling
   localparam int MW    = 33;   // multiplier operand
   localparam int PW    = 2 * MW;
   localparam int CW    = 36;   // cordic x, y, z
   localparam int SQ_W  = 62;   // square root operand and remainder
   localparam int AW    = 31;   // haversine term a, Q1.30 in [0, 1]

   localparam int ITERS    = 30;
   localparam int SQ_ITERS = 31;
   localparam int CNT_W    = 5;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   localparam logic [63:0] DEG7_TO_Q62 = 64'd8048910509;
   localparam logic [15:0] K_LO        = DEG7_TO_Q62[15:0];
   localparam logic [16:0] K_HI        = DEG7_TO_Q62[32:16];

   localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic [31:0]          HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0]          PI_Q30      = 32'd3373259426;
   localparam logic [AW-1:0]        ONE_Q30     = 31'h40000000;

   localparam logic signed [DW-1:0] HALF_TURN = 34'sd1800000000;
   localparam logic signed [DW-1:0] FULL_TURN = 34'sd3600000000;

   // which angle the shared cordic is working on
   localparam logic [1:0] ANG_DLAT     = 2'd0;
   localparam logic [1:0] ANG_DLON     = 2'd1;
   localparam logic [1:0] ANG_LAT_PREV = 2'd2;
   localparam logic [1:0] ANG_LAT_CUR  = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_MAG,
      OP_MLO,
      OP_MHI,
      OP_SUM,
      OP_ANG,
      OP_ROT,
      OP_RSTORE,
      OP_SQ1,
      OP_SQ2,
      OP_CC,
      OP_A1,
      OP_A2,
      OP_A3,
      OP_SQRT,
      OP_VINIT,
      OP_VEC,
      OP_RAD,
      OP_FIN,
      OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] iter;
      logic [1:0]       idx;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic have_prev;
      logic y_zero;
   } status_type;

   function automatic logic signed [CW-1:0] atan_q30(input logic [CNT_W-1:0] i);
      logic [29:0] t;
      case (i)
         5'd0:  t = 30'h3243F6A8;
         5'd1:  t = 30'h1DAC6705;
         5'd2:  t = 30'h0FADBAFC;
         5'd3:  t = 30'h07F56EA6;
         5'd4:  t = 30'h03FEAB76;
         5'd5:  t = 30'h01FFD55B;
         5'd6:  t = 30'h00FFFAAA;
         5'd7:  t = 30'h007FFF55;
         5'd8:  t = 30'h003FFFEA;
         5'd9:  t = 30'h001FFFFD;
         5'd10: t = 30'h000FFFFF;
         5'd11: t = 30'h0007FFFF;
         5'd12: t = 30'h0003FFFF;
         5'd13: t = 30'h0001FFFF;
         5'd14: t = 30'h0000FFFF;
         5'd15: t = 30'h00007FFF;
         5'd16: t = 30'h00003FFF;
         5'd17: t = 30'h00001FFF;
         5'd18: t = 30'h00000FFF;
         5'd19: t = 30'h000007FF;
         5'd20: t = 30'h000003FF;
         5'd21: t = 30'h000001FF;
         5'd22: t = 30'h000000FF;
         5'd23: t = 30'h0000007F;
         5'd24: t = 30'h0000003F;
         5'd25: t = 30'h0000001F;
         5'd26: t = 30'h0000000F;
         5'd27: t = 30'h00000007;
         5'd28: t = 30'h00000003;
         5'd29: t = 30'h00000001;
         default: t = '0;
      endcase
      return {{(CW-30){1'b0}}, t};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hpl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ctrl
// sequencer: walks one waypoint through diff, four cordic rotations, the
// haversine products, two square roots, cordic vectoring and the final scale
// ----------------------------------------------------------------------------
module hpl_ctrl import hpl_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [20:0] {
      ST_IDLE   = 21'h000001,
      ST_DIFF   = 21'h000002,
      ST_MAG    = 21'h000004,
      ST_MLO    = 21'h000008,
      ST_MHI    = 21'h000010,
      ST_SUM    = 21'h000020,
      ST_ANG    = 21'h000040,
      ST_ROT    = 21'h000080,
      ST_RSTORE = 21'h000100,
      ST_SQ1    = 21'h000200,
      ST_SQ2    = 21'h000400,
      ST_CC     = 21'h000800,
      ST_A1     = 21'h001000,
      ST_A2     = 21'h002000,
      ST_A3     = 21'h004000,
      ST_SQRT   = 21'h008000,
      ST_VINIT  = 21'h010000,
      ST_VEC    = 21'h020000,
      ST_RAD    = 21'h040000,
      ST_FIN    = 21'h080000,
      ST_DONE   = 21'h100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      commit   = 1'b0;
      cmd.op   = OP_NONE;
      cmd.iter = cnt_ff;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op = OP_DIFF;
            if (status.mode || !status.have_prev) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cmd.op   = OP_MAG;
            idx_in   = ANG_DLAT;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            cmd.op   = OP_MLO;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.op   = OP_MHI;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.op   = OP_ANG;
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.op = OP_ROT;
            if (cnt_ff == CNT_W'(ITERS - 1)) begin
               state_in = ST_RSTORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RSTORE: begin
            cmd.op = OP_RSTORE;
            if (idx_ff == ANG_LAT_CUR) begin
               state_in = ST_SQ1;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MLO;
            end
         end
         ST_SQ1: begin
            cmd.op   = OP_SQ1;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.op   = OP_SQ2;
            state_in = ST_CC;
         end
         ST_CC: begin
            cmd.op   = OP_CC;
            state_in = ST_A1;
         end
         ST_A1: begin
            cmd.op   = OP_A1;
            state_in = ST_A2;
         end
         ST_A2: begin
            cmd.op   = OP_A2;
            state_in = ST_A3;
         end
         ST_A3: begin
            cmd.op   = OP_A3;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (cnt_ff == CNT_W'(SQ_ITERS - 1)) begin
               state_in = ST_VINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_VINIT: begin
            cmd.op = OP_VINIT;
            cnt_in = '0;
            // coincident points: angle is zero, skip vectoring
            if (status.y_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            cmd.op = OP_VEC;
            if (cnt_ff == CNT_W'(ITERS - 1)) begin
               state_in = ST_RAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RAD: begin
            cmd.op   = OP_RAD;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_COMMIT;
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/hpl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_datapath
// journey state, shared multiplier, shared rotate/vector cordic, two-lane
// bit-serial square root and the result registers
// ----------------------------------------------------------------------------
module hpl_datapath import hpl_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  wire                        req_mode,
   input  wire signed [LAT_W-1:0]     req_latitude,
   input  wire signed [LON_W-1:0]     req_longitude,
   input  wire                        csr_we,
   input  wire        [RADIUS_W-1:0]  csr_earth_radius_m,
   output logic       [STEP_W-1:0]    out_step,
   output logic       [TOTAL_BITS-1:0] out_total,
   output logic                       out_first
);

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   // journey state and configuration
   logic [RADIUS_W-1:0]   radius_ff;
   logic                  have_prev_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic signed [POS_W-1:0] prev_lat_ff, prev_lon_ff;

   // current item
   logic                    mode_ff;
   logic signed [POS_W-1:0] cur_lat_ff, cur_lon_ff;
   logic signed [DW-1:0]    dlat_ff, dlon_ff;
   logic [MAG_W-1:0]        mag_ff [4];
   logic [1:0]              neg_ff;

   // arithmetic
   logic signed [PW-1:0] prod_ff;
   logic [64:0]          acc_ff;
   logic                 fold_ff;
   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic signed [MW-1:0] s1_ff, s2_ff, c1_ff, c2_ff;
   logic signed [MW-1:0] s1sq_ff, s2sq_ff, cc_ff;
   logic [SQ_W-1:0]      sqv_ff [2];
   logic [SQ_W-1:0]      sqr_ff [2];
   logic [STEP_W-1:0]    step_ff;

   // combinational helpers
   logic signed [DW-1:0]  dlat_raw, dlon_raw, dlat_wr, dlon_wr;
   logic signed [DW-1:0]  dlat_abs, dlon_abs;
   logic signed [POS_W-1:0] plat_abs, clat_abs;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  mul_p;
   logic [64:0]           rnd;
   logic [30:0]           half_ang;
   logic [31:0]           p_ang;
   logic                  p_fold;
   logic signed [CW-1:0]  half_z, ang_z;
   logic signed [CW-1:0]  dx, dy, t_ang;
   logic                  plus;
   logic signed [CW-1:0]  neg_x;
   logic signed [MW+1:0]  a_sum;
   logic [AW-1:0]         a_cl;
   logic [5:0]            sq_sh;
   logic [SQ_W-1:0]       sq_bit;
   logic [SQ_W-1:0]       trial [2];
   logic [31:0]           z_cl;
   logic [32:0]           cang;
   logic [PW-1:0]         q_scaled;
   logic [TOTAL_BITS:0]   total_sum;
   logic [TOTAL_BITS-1:0] total_sat;

   function automatic logic signed [DW-1:0] wrap_turn(input logic signed [DW-1:0] d);
      logic signed [DW-1:0] r;
      r = d;
      if (d >= HALF_TURN) begin
         r = d - FULL_TURN;
      end else if (d < -HALF_TURN) begin
         r = d + FULL_TURN;
      end
      return r;
   endfunction

   assign status.mode      = mode_ff;
   assign status.have_prev = have_prev_ff;
   assign status.y_zero    = (sqr_ff[0] == '0);

   always_comb begin
      dlat_raw = {{(DW-POS_W){cur_lat_ff[POS_W-1]}}, cur_lat_ff}
               - {{(DW-POS_W){prev_lat_ff[POS_W-1]}}, prev_lat_ff};
      dlon_raw = {{(DW-POS_W){cur_lon_ff[POS_W-1]}}, cur_lon_ff}
               - {{(DW-POS_W){prev_lon_ff[POS_W-1]}}, prev_lon_ff};
      dlat_wr  = wrap_turn(dlat_raw);
      dlon_wr  = wrap_turn(dlon_raw);
      dlat_abs = dlat_ff[DW-1] ? -dlat_ff : dlat_ff;
      dlon_abs = dlon_ff[DW-1] ? -dlon_ff : dlon_ff;
      plat_abs = prev_lat_ff[POS_W-1] ? -prev_lat_ff : prev_lat_ff;
      clat_abs = cur_lat_ff[POS_W-1] ? -cur_lat_ff : cur_lat_ff;
   end

   // shared multiplier, operands steered by the command
   always_comb begin
      z_cl = z_ff[CW-1] ? '0 :
             (z_ff > $signed({{(CW-32){1'b0}}, HALF_PI_Q30})) ? HALF_PI_Q30 : z_ff[31:0];
      cang = {z_cl, 1'b0};
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MLO: begin
            mul_a = {{(MW-MAG_W){1'b0}}, mag_ff[cmd.idx]};
            mul_b = {{(MW-16){1'b0}}, K_LO};
         end
         OP_MHI: begin
            mul_a = {{(MW-MAG_W){1'b0}}, mag_ff[cmd.idx]};
            mul_b = {{(MW-17){1'b0}}, K_HI};
         end
         OP_SQ1: begin
            mul_a = s1_ff;
            mul_b = s1_ff;
         end
         OP_SQ2: begin
            mul_a = s2_ff;
            mul_b = s2_ff;
         end
         OP_CC: begin
            mul_a = c1_ff;
            mul_b = c2_ff;
         end
         OP_A2: begin
            mul_a = cc_ff;
            mul_b = s2sq_ff;
         end
         OP_RAD: begin
            mul_a = cang;
            mul_b = {{(MW-RADIUS_W){1'b0}}, radius_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // angle scaling and cordic step
   always_comb begin
      rnd      = (cmd.idx == ANG_DLAT || cmd.idx == ANG_DLON) ? (65'd1 << 32) : (65'd1 << 31);
      half_ang = acc_ff[63:33];
      p_ang    = acc_ff[63:32];
      p_fold   = (p_ang > HALF_PI_Q30);
      half_z   = {{(CW-31){1'b0}}, half_ang};
      if (cmd.idx == ANG_DLAT) begin
         ang_z = neg_ff[0] ? -half_z : half_z;
      end else if (cmd.idx == ANG_DLON) begin
         ang_z = neg_ff[1] ? -half_z : half_z;
      end else begin
         ang_z = {{(CW-32){1'b0}}, (p_fold ? (PI_Q30 - p_ang) : p_ang)};
      end
      dx    = y_ff >>> cmd.iter;
      dy    = x_ff >>> cmd.iter;
      t_ang = atan_q30(cmd.iter);
      if (cmd.op == OP_ROT) begin
         plus = !z_ff[CW-1];
      end else begin
         plus = !(!y_ff[CW-1] && (y_ff != '0));
      end
      neg_x = -x_ff;
   end

   // haversine term, square root lanes, final scale, saturating total
   always_comb begin
      a_sum = {{2{s1sq_ff[MW-1]}}, s1sq_ff} + {prod_ff[PW-1], prod_ff[63:30]};
      if (a_sum[MW+1]) begin
         a_cl = '0;
      end else if (a_sum > $signed({{(MW+2-AW){1'b0}}, ONE_Q30})) begin
         a_cl = ONE_Q30;
      end else begin
         a_cl = a_sum[AW-1:0];
      end
      sq_sh  = 6'd60 - {cmd.iter, 1'b0};
      sq_bit = {{(SQ_W-1){1'b0}}, 1'b1} << sq_sh;
      for (int l = 0; l < 2; l++) begin
         trial[l] = sqr_ff[l] + sq_bit;
      end
      q_scaled = ({{(PW-55){1'b0}}, prod_ff[54:0]} << 10)
               - ({{(PW-55){1'b0}}, prod_ff[54:0]} << 4)
               - ({{(PW-55){1'b0}}, prod_ff[54:0]} << 3)
               + (PW'(1) << 29);
      total_sum = {1'b0, total_ff} + {{(TOTAL_BITS+1-STEP_W){1'b0}}, step_ff};
      total_sat = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
   end

   // control state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
      end else begin
         if (csr_we) begin
            radius_ff <= csr_earth_radius_m;
         end
         if (cmd.op == OP_COMMIT) begin
            if (mode_ff) begin
               have_prev_ff <= 1'b0;
               total_ff     <= '0;
               prev_lat_ff  <= '0;
               prev_lon_ff  <= '0;
            end else begin
               have_prev_ff <= 1'b1;
               prev_lat_ff  <= cur_lat_ff;
               prev_lon_ff  <= cur_lon_ff;
               if (have_prev_ff) begin
                  total_ff <= total_sat;
               end
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            mode_ff    <= req_mode;
            cur_lat_ff <= {req_latitude[LAT_W-1], req_latitude};
            cur_lon_ff <= req_longitude;
            step_ff    <= '0;
         end
         OP_DIFF: begin
            dlat_ff <= dlat_wr;
            dlon_ff <= dlon_wr;
         end
         OP_MAG: begin
            mag_ff[ANG_DLAT]     <= dlat_abs[MAG_W-1:0];
            mag_ff[ANG_DLON]     <= dlon_abs[MAG_W-1:0];
            mag_ff[ANG_LAT_PREV] <= plat_abs[MAG_W-1:0];
            mag_ff[ANG_LAT_CUR]  <= clat_abs[MAG_W-1:0];
            neg_ff               <= {dlon_ff[DW-1], dlat_ff[DW-1]};
         end
         OP_MLO: begin
            prod_ff <= mul_p;
         end
         OP_MHI: begin
            acc_ff  <= prod_ff[64:0];
            prod_ff <= mul_p;
         end
         OP_SUM: begin
            acc_ff <= acc_ff + {prod_ff[48:0], 16'b0} + rnd;
         end
         OP_ANG: begin
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= ang_z;
            fold_ff <= (cmd.idx == ANG_LAT_PREV || cmd.idx == ANG_LAT_CUR) && p_fold;
         end
         OP_ROT, OP_VEC: begin
            if (plus) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - t_ang;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + t_ang;
            end
         end
         OP_RSTORE: begin
            case (cmd.idx)
               ANG_DLAT:     s1_ff <= y_ff[MW-1:0];
               ANG_DLON:     s2_ff <= y_ff[MW-1:0];
               ANG_LAT_PREV: c1_ff <= fold_ff ? neg_x[MW-1:0] : x_ff[MW-1:0];
               ANG_LAT_CUR:  c2_ff <= fold_ff ? neg_x[MW-1:0] : x_ff[MW-1:0];
               default:      c2_ff <= x_ff[MW-1:0];
            endcase
         end
         OP_SQ1: begin
            prod_ff <= mul_p;
         end
         OP_SQ2: begin
            s1sq_ff <= prod_ff[30+MW-1:30];
            prod_ff <= mul_p;
         end
         OP_CC: begin
            s2sq_ff <= prod_ff[30+MW-1:30];
            prod_ff <= mul_p;
         end
         OP_A1: begin
            cc_ff <= prod_ff[30+MW-1:30];
         end
         OP_A2: begin
            prod_ff <= mul_p;
         end
         OP_A3: begin
            sqv_ff[0] <= {{(SQ_W-AW-30){1'b0}}, a_cl, 30'b0};
            sqv_ff[1] <= {{(SQ_W-AW-30){1'b0}}, (ONE_Q30 - a_cl), 30'b0};
            sqr_ff[0] <= '0;
            sqr_ff[1] <= '0;
         end
         OP_SQRT: begin
            for (int l = 0; l < 2; l++) begin
               if (sqv_ff[l] >= trial[l]) begin
                  sqv_ff[l] <= sqv_ff[l] - trial[l];
                  sqr_ff[l] <= (sqr_ff[l] >> 1) + sq_bit;
               end else begin
                  sqr_ff[l] <= sqr_ff[l] >> 1;
               end
            end
         end
         OP_VINIT: begin
            x_ff <= {{(CW-31){1'b0}}, sqr_ff[1][30:0]};
            y_ff <= {{(CW-31){1'b0}}, sqr_ff[0][30:0]};
            z_ff <= '0;
         end
         OP_RAD: begin
            prod_ff <= mul_p;
         end
         OP_FIN: begin
            step_ff <= q_scaled[STEP_W+29:30];
         end
         OP_COMMIT: begin
            if (mode_ff) begin
               out_step  <= '0;
               out_total <= '0;
               out_first <= 1'b0;
            end else if (have_prev_ff) begin
               out_step  <= step_ff;
               out_total <= total_sat;
               out_first <= 1'b0;
            end else begin
               out_step  <= '0;
               out_total <= total_ff;
               out_first <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/haversine_path_length.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_path_length
// great-circle path length over a stream of waypoints, in millimetres
// ----------------------------------------------------------------------------
// Send waypoints (1e-7 degree) or clear commands on req_; each one gives
// exactly one result on rsp_: the leg distance to the previous waypoint, the
// saturating running total and a first-point flag. Work is done one item at
// a time. For a waypoint with a previous point the bulk of the work is one
// shared cordic making five 30-step passes (four rotations for sin/cos, one
// vectoring pass for the angle, skipped when both points coincide) and a
// 31-step bit-serial square root, then the radius scaling. A clear
// command or the first waypoint skips all of it. A finished result waits in
// the output register, so the next item can be taken while rsp_valid is
// still high; that item then holds in its last cycle until the pending
// result transfers. The earth radius on csr_ is always accepted and should
// only be changed while no item is in flight.
// ----------------------------------------------------------------------------
module haversine_path_length import hpl_pkg::*; (
   input  wire                         clock,
   input  wire                         reset,
   // waypoint / clear transfer
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_mode,
   input  wire signed [LAT_W-1:0]      req_latitude,
   input  wire signed [LON_W-1:0]      req_longitude,
   // result transfer
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic        [STEP_W-1:0]    rsp_step_distance,
   output logic        [TOTAL_BITS-1:0] rsp_total_length,
   output logic                        rsp_first_point,
   // radius register write
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire         [RADIUS_W-1:0]  csr_earth_radius_m
);

   cmd_type    cmd;
   status_type status;

   // radius write is registered at its transfer and never stalls
   assign csr_ready = 1'b1;

   // sequencer
   hpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, journey state and result register
   hpl_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_latitude       (req_latitude),
      .req_longitude      (req_longitude),
      .csr_we             (csr_valid),
      .csr_earth_radius_m (csr_earth_radius_m),
      .out_step           (rsp_step_distance),
      .out_total          (rsp_total_length),
      .out_first          (rsp_first_point)
   );

endmodule
`default_nettype wire

// ===== rtl/hpl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_checker
// port-level checks on the haversine path length block
// ----------------------------------------------------------------------------
module hpl_checker import hpl_pkg::*; (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        req_mode,
   input wire signed [LAT_W-1:0]     req_latitude,
   input wire signed [LON_W-1:0]     req_longitude,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire        [STEP_W-1:0]    rsp_step_distance,
   input wire        [TOTAL_BITS-1:0] rsp_total_length,
   input wire                        rsp_first_point,
   input wire                        csr_valid,
   input wire                        csr_ready,
   input wire        [RADIUS_W-1:0]  csr_earth_radius_m
);

   // a pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_distance)
         && $stable(rsp_total_length) && $stable(rsp_first_point))
      else $error("result changed before transfer");

   // no result pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a first point never carries a distance
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_point |-> rsp_step_distance == '0)
      else $error("first point with nonzero distance");

   // no item finishes in the cycle right after a request transfer
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind haversine_path_length hpl_checker u_hpl_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_haversine_path_length.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haversine_path_length
// Self-checking bench for the great-circle path length block. A bit-exact
// integer model of the haversine leg (cordic sin/cos, integer square root,
// cordic vectoring, radius scaling) and of the running total tracks every
// accepted waypoint. Each result is checked against it field by field.
// Directed journeys cover the corner cases, then random journeys run under
// several idle and stall patterns and several radius settings.
// ----------------------------------------------------------------------------
module tb_haversine_path_length import hpl_pkg::*; ();

   localparam longint unsigned DEG7_SCALE  = 64'd8048910509;
   localparam longint          GAIN_START  = 652032874;
   localparam longint          QUARTER_RAD = 1686629713;
   localparam longint          HALF_RAD    = 64'sd3373259426;
   localparam longint          UNIT_Q30    = 1073741824;
   localparam longint          DEG_HALF    = 1800000000;
   localparam longint          DEG_FULL    = 64'sd3600000000;
   localparam longint unsigned TOTAL_MAX   = (64'd1 << TOTAL_BITS) - 1;

   typedef struct {
      logic [STEP_W-1:0]     step;
      logic [TOTAL_BITS-1:0] total;
      logic                  first;
   } leg_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_mode;
   logic signed [LAT_W-1:0] req_latitude;
   logic signed [LON_W-1:0] req_longitude;
   logic rsp_valid;
   logic rsp_ready;
   logic [STEP_W-1:0] rsp_step_distance;
   logic [TOTAL_BITS-1:0] rsp_total_length;
   logic rsp_first_point;
   logic csr_valid;
   logic csr_ready;
   logic [RADIUS_W-1:0] csr_earth_radius_m;

   // predictor state
   leg_result_type  expected_legs[$];
   logic [RADIUS_W-1:0] model_radius;
   longint          last_lat;
   longint          last_lon;
   logic            have_last;
   longint unsigned path_total;

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;
   // stimulus-side memory of the last waypoint sent
   longint trip_lat;
   longint trip_lon;

   haversine_path_length DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_latitude       (req_latitude),
      .req_longitude      (req_longitude),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_step_distance  (rsp_step_distance),
      .rsp_total_length   (rsp_total_length),
      .rsp_first_point    (rsp_first_point),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_earth_radius_m (csr_earth_radius_m)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop if the block hangs
   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // integer model of one leg
   // ------------------------------------------------------------------------
   function automatic longint arctan_step(input int i);
      case (i)
         0: return 64'h3243F6A8;   1: return 64'h1DAC6705;
         2: return 64'h0FADBAFC;   3: return 64'h07F56EA6;
         4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
         6: return 64'h00FFFAAA;   7: return 64'h007FFF55;
         8: return 64'h003FFFEA;   9: return 64'h001FFFFD;
         default: return (64'd1 << (30 - i)) - 1;   // tail of the table
      endcase
   endfunction

   function automatic void cordic_rotation(input longint angle, output longint sn,
                                           output longint cs);
      longint x, y, z, dx, dy;
      x = GAIN_START;
      y = 0;
      z = angle;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      sn = y;
      cs = x;
   endfunction

   function automatic longint cordic_vectoring(input longint y0, input longint x0);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_step(i);
         end else begin
            x -= dx; y += dy; z -= arctan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_RAD) z = QUARTER_RAD;
      return z;
   endfunction

   function automatic longint unsigned integer_sqrt(input longint unsigned v);
      longint unsigned rem, root, b;
      rem = v;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // sine of half a coordinate difference, difference wrapped once
   function automatic longint sine_half_delta(input longint d);
      longint delta, half, sn, cs;
      longint unsigned mag;
      delta = d;
      if (delta >= DEG_HALF) delta -= DEG_FULL;
      if (delta < -DEG_HALF) delta += DEG_FULL;
      mag = (delta < 0) ? -delta : delta;
      half = longint'((mag * DEG7_SCALE + (64'd1 << 32)) >> 33);
      if (delta < 0) half = -half;
      cordic_rotation(half, sn, cs);
      return sn;
   endfunction

   // cosine of a latitude; past 90 degrees it folds back and flips sign
   function automatic longint cosine_of_latitude(input longint lat);
      longint p, sn, cs;
      longint unsigned mag;
      logic folded;
      mag = (lat < 0) ? -lat : lat;
      p = longint'((mag * DEG7_SCALE + (64'd1 << 31)) >> 32);
      folded = p > QUARTER_RAD;
      if (folded) p = HALF_RAD - p;
      cordic_rotation(p, sn, cs);
      return folded ? -cs : cs;
   endfunction

   function automatic longint unsigned leg_distance_mm(input longint lat1,
         input longint lon1, input longint lat2, input longint lon2);
      longint s1, s2, c1, c2, s1sq, s2sq, cc, hav;
      longint unsigned ya, xa, q, central;
      s1 = sine_half_delta(lat2 - lat1);
      s2 = sine_half_delta(lon2 - lon1);
      c1 = cosine_of_latitude(lat1);
      c2 = cosine_of_latitude(lat2);
      s1sq = longint'(longint'(s1 * s1) >> 30);
      s2sq = longint'(longint'(s2 * s2) >> 30);
      cc = (c1 * c2) >>> 30;
      hav = s1sq + ((cc * s2sq) >>> 30);
      if (hav < 0) hav = 0;
      if (hav > UNIT_Q30) hav = UNIT_Q30;
      ya = integer_sqrt(longint'(hav) << 30);
      xa = integer_sqrt(longint'(UNIT_Q30 - hav) << 30);
      // coincident points give a zero angle
      if (ya == 0) return 0;
      central = 2 * cordic_vectoring(ya, xa);
      q = central * longint'(model_radius);
      return (q >> 30) * 1000 + (((q & 64'h3FFFFFFF) * 1000 + (64'd1 << 29)) >> 30);
   endfunction

   // advance the journey model by one accepted item
   function automatic void track_waypoint(input logic m, input longint lat,
                                          input longint lon);
      leg_result_type leg;
      longint unsigned leg_mm;
      leg_mm = 0;
      leg.first = 1'b0;
      if (m) begin
         // clear: forget everything
         last_lat = 0;
         last_lon = 0;
         have_last = 1'b0;
         path_total = 0;
      end else begin
         if (have_last) begin
            leg_mm = leg_distance_mm(last_lat, last_lon, lat, lon);
            if (path_total > TOTAL_MAX - leg_mm) path_total = TOTAL_MAX;
            else path_total += leg_mm;
         end else begin
            leg.first = 1'b1;
         end
         last_lat = lat;
         last_lon = lon;
         have_last = 1'b1;
      end
      leg.step = leg_mm[STEP_W-1:0];
      leg.total = path_total[TOTAL_BITS-1:0];
      expected_legs.insert(expected_legs.size(), leg);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // monitors: transfers are sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      leg_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            model_radius = csr_earth_radius_m;
         if (req_valid && req_ready)
            track_waypoint(req_mode, longint'(req_latitude), longint'(req_longitude));
         if (rsp_valid && rsp_ready) begin
            if (expected_legs.size() == 0) begin
               report_mismatch("unexpected result", rsp_step_distance, 0);
            end else begin
               want = expected_legs.pop_front();
               if (rsp_step_distance !== want.step)
                  report_mismatch("step_distance", rsp_step_distance, want.step);
               if (rsp_total_length !== want.total)
                  report_mismatch("total_length", rsp_total_length, want.total);
               if (rsp_first_point !== want.first)
                  report_mismatch("first_point", rsp_first_point, want.first);
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // ------------------------------------------------------------------------
   // drivers: everything changes on the falling edge
   // ------------------------------------------------------------------------
   task automatic send_item(input logic m, input longint lat, input longint lon);
      // random idle gap; valid drops only when a gap is taken
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_latitude <= lat[LAT_W-1:0];
      req_longitude <= lon[LON_W-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!m) begin
         trip_lat = lat;
         trip_lon = lon;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_legs.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] radius);
      wait_idle();
      csr_valid <= 1'b1;
      csr_earth_radius_m <= radius;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_first_and_identical();
      send_item(1'b0, 515000000, -1270000);     // first point after reset
      send_item(1'b0, 515000000, -1270000);     // same point, zero leg
      send_item(1'b0, 488566000, 23522000);     // ordinary leg
      send_item(1'b0, 488566001, 23522000);     // tiny leg
   endtask

   task automatic test_coordinate_extremes();
      send_item(1'b0, 900000000, 0);            // north pole
      send_item(1'b0, -900000000, 1800000000);  // south pole
      send_item(1'b0, 0, 0);
      send_item(1'b0, 0, 1800000000);           // antipodal on the equator
      send_item(1'b0, -1073741824, -64'sd2147483648); // latitude past 90 degrees
      send_item(1'b0, 1073741823, 2147483647);
      send_item(1'b0, -1800000000 / 2, -1800000000);
   endtask

   task automatic test_longitude_wrap();
      send_item(1'b0, 100000000, 1799999999);
      send_item(1'b0, 100000000, -1799999999);  // crosses the date line
      send_item(1'b0, -100000000, 1799999000);
      send_item(1'b0, 0, -1800000000);
   endtask

   task automatic test_clear_journey();
      send_item(1'b1, 123456789, -987654321);   // clear ignores coordinates
      send_item(1'b0, 400000000, 100000000);    // first point after clear
      send_item(1'b0, 410000000, 110000000);
      send_item(1'b1, -1, -1);
      send_item(1'b1, 0, 0);                    // clear on an empty journey
      send_item(1'b0, 0, 0);
   endtask

   // mostly plausible journeys, some clears and wild jumps
   task automatic test_random_journeys(input int count);
      int pick;
      longint lat, lon;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_item(1'b1, longint'($signed($urandom)), longint'($signed($urandom)));
         end else begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               lat = longint'($signed($urandom)) >>> 1;   // any 31-bit value
               lon = longint'($signed($urandom));
            end else if (pick == 1) begin
               lat = trip_lat;
               lon = trip_lon;
            end else if (pick == 2) begin
               lat = -trip_lat;
               lon = trip_lon + ((trip_lon < 0) ? DEG_HALF : -DEG_HALF);
            end else begin
               lat = trip_lat + $signed($urandom_range(4000000)) - 2000000;
               lon = trip_lon + $signed($urandom_range(6000000)) - 3000000;
               if (lat > 900000000) lat = 900000000;
               if (lat < -900000000) lat = -900000000;
               if (lon >= DEG_HALF) lon -= DEG_FULL;
               if (lon < -DEG_HALF) lon += DEG_FULL;
            end
            send_item(1'b0, lat, lon);
         end
      end
   endtask

   initial begin
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      model_radius = RADIUS_RESET;
      last_lat = 0;
      last_lon = 0;
      have_last = 1'b0;
      path_total = 0;
      trip_lat = 0;
      trip_lon = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_latitude = '0;
      req_longitude = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_earth_radius_m = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_first_and_identical();
      test_coordinate_extremes();
      test_longitude_wrap();
      test_clear_journey();

      // random journeys: radius and idle pattern change between phases
      write_radius(23'd6300000);
      test_random_journeys(110);
      write_radius(23'd6400000);
      send_idle_pct = 84;
      test_random_journeys(110);
      write_radius(23'h7FFFFF);
      send_idle_pct = 0;
      recv_stall_pct = 84;
      test_random_journeys(110);
      write_radius(23'd0);
      send_item(1'b0, 200000000, 300000000);    // zero radius gives zero legs
      send_item(1'b0, -200000000, -300000000);
      write_radius(23'd6371000);
      send_idle_pct = 26;
      recv_stall_pct = 26;
      test_random_journeys(110);

      wait_idle();
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
